// ----- rtl/core/flow_field_layer_superposition_defines.svh -----
`ifndef FLOW_FIELD_LAYER_SUPERPOSITION_DEFINES_SVH
`define FLOW_FIELD_LAYER_SUPERPOSITION_DEFINES_SVH

// Assertion helpers shared by the checker.
`define FFLS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("flow field assertion failed");

`define FFLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("flow field assertion failed");

`endif

// ----- rtl/core/ffls_pkg.sv -----
`default_nettype none
package ffls_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int REQ_DATA_BITS = 248;
   localparam int RSP_DATA_BITS = 64;

   localparam logic [2:0] KIND_VORTEX  = 3'd0;
   localparam logic [2:0] KIND_UNIFORM = 3'd1;
   localparam logic [2:0] KIND_SOURCE  = 3'd2;
   localparam logic [2:0] KIND_SINK    = 3'd3;
   localparam logic [2:0] KIND_SADDLE  = 3'd4;
   localparam logic [2:0] KIND_SPIRAL  = 3'd5;

   localparam logic [16:0] ONE_Q16 = 17'd65536;
   localparam longint DEG_FULL = 64'd360 << 16;
   localparam longint DEG_HALF = 64'd180 << 16;
   localparam longint DEG_QUART = 64'd90 << 16;
   localparam longint KINV = 64'd652032874;

   typedef struct packed {
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic [2:0]         kind;
      logic signed [31:0] angle;
      logic [16:0]        blend;
      logic signed [31:0] weight;
      logic [16:0]        decay;
      logic               last;
   } ffls_item_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_NORM, ST_MOD, ST_FOLD, ST_ITER, ST_ROUND, ST_SPX, ST_SPY,
      ST_WX, ST_WY, ST_ACC, ST_DX, ST_DY, ST_PUSH
   } ffls_state_type;

   function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
      logic signed [31:0] v;
      unique case (i)
         5'd0: v = 32'sd754974720;
         5'd1: v = 32'sd445687602;
         5'd2: v = 32'sd235489088;
         5'd3: v = 32'sd119537938;
         5'd4: v = 32'sd60000934;
         5'd5: v = 32'sd30029717;
         5'd6: v = 32'sd15018523;
         5'd7: v = 32'sd7509720;
         5'd8: v = 32'sd3754917;
         5'd9: v = 32'sd1877466;
         5'd10: v = 32'sd938734;
         5'd11: v = 32'sd469367;
         5'd12: v = 32'sd234684;
         5'd13: v = 32'sd117342;
         5'd14: v = 32'sd58671;
         5'd15: v = 32'sd29335;
         5'd16: v = 32'sd14668;
         5'd17: v = 32'sd7334;
         5'd18: v = 32'sd3667;
         5'd19: v = 32'sd1833;
         5'd20: v = 32'sd917;
         5'd21: v = 32'sd458;
         5'd22: v = 32'sd229;
         5'd23: v = 32'sd115;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/flow_field_layer_superposition.sv -----
// Flow: a uniform layer takes the angle reduction, a directed one with nonzero offset the
// normalize shift, then both run the shared CORDIC unit (CORDIC_STEPS iterations); a last
// layer then adds damping and output. The back end takes one item at a time, pops the next
// only when idle, and a last layer waits until the output is free.
// Reset: synchronous, active high; it empties the queue, clears both accumulators
// and drops the result valid.
`default_nettype none
module flow_field_layer_superposition import ffls_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // pos_x, pos_y, center_x, center_y, angle_deg, sink_blend, weight, decay, zero fill
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   // layer_kind
   input  wire logic [2:0]               req_tuser,
   input  wire logic                     req_tlast,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // field_x, field_y
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata
);

   logic          q_valid;
   logic          q_pop;
   ffls_item_type q_item;

   ffls_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   ffls_back #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

// ----- rtl/core/ffls_front.sv -----
`default_nettype none
module ffls_front import ffls_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   input  wire logic [2:0]               req_tuser,
   input  wire logic                     req_tlast,
   output logic                          q_valid,
   output ffls_item_type                 q_item,
   input  wire logic                     q_pop
);

   ffls_item_type      item_in;
   ffls_item_type      entry_ff [2];
   logic               wr_ptr_ff;
   logic               rd_ptr_ff;
   logic [1:0]         count_ff;
   logic               push;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] center_x;
   logic signed [31:0] center_y;
   logic signed [31:0] blend_raw;
   logic [16:0]        decay_raw;

   always_comb begin
      pos_x     = $signed(req_tdata[31:0]);
      pos_y     = $signed(req_tdata[63:32]);
      center_x  = $signed(req_tdata[95:64]);
      center_y  = $signed(req_tdata[127:96]);
      blend_raw = $signed(req_tdata[191:160]);
      decay_raw = req_tdata[240:224];
      item_in.dx     = 33'(pos_x) - 33'(center_x);
      item_in.dy     = 33'(pos_y) - 33'(center_y);
      item_in.kind   = req_tuser;
      item_in.angle  = $signed(req_tdata[159:128]);
      item_in.weight = $signed(req_tdata[223:192]);
      item_in.last   = req_tlast;
      priority if (blend_raw < 0) begin
         item_in.blend = '0;
      end else if (blend_raw > $signed({15'd0, ONE_Q16})) begin
         item_in.blend = ONE_Q16;
      end else begin
         item_in.blend = blend_raw[16:0];
      end
      item_in.decay = (decay_raw > ONE_Q16) ? ONE_Q16 : decay_raw;
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_item     = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(q_pop);
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/ffls_back.sv -----
`default_nettype none
module ffls_back import ffls_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     q_valid,
   input  wire ffls_item_type            q_item,
   output logic                          q_pop,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata
);

   localparam int CW = $clog2(CORDIC_STEPS);
   localparam logic signed [33:0] FULL_S = 34'(DEG_FULL);
   localparam logic signed [33:0] HALF_S = 34'(DEG_HALF);
   localparam logic signed [33:0] QUART_S = 34'(DEG_QUART);
   localparam logic [33:0] MOD_BIAS = 34'(DEG_FULL * 92);
   localparam logic [40:0] NORM_LOW = 41'd1 << 40;
   localparam logic [40:0] COARSE_LIM = 41'd1 << 33;

   ffls_state_type     state_ff;
   ffls_state_type     state_in;
   logic [2:0]         kind_ff;
   logic [16:0]        blend_ff;
   logic signed [31:0] weight_ff;
   logic [16:0]        decay_ff;
   logic               last_ff;
   logic signed [45:0] x_ff;
   logic signed [45:0] y_ff;
   logic [40:0]        m_ff;
   logic signed [33:0] z_ff;
   logic [33:0]        u_ff;
   logic [3:0]         k_ff;
   logic signed [33:0] c_ff;
   logic signed [33:0] s_ff;
   logic [CW-1:0]      iter_ff;
   logic               vec_ff;
   logic               neg_ff;
   logic               ok_ff;
   logic signed [17:0] ux_ff;
   logic signed [17:0] uy_ff;
   logic signed [17:0] vx_ff;
   logic signed [17:0] vy_ff;
   logic signed [33:0] wx_ff;
   logic signed [33:0] wy_ff;
   logic signed [39:0] acc_x_ff;
   logic signed [39:0] acc_y_ff;
   logic signed [31:0] fx_ff;
   logic signed [31:0] fy_ff;
   logic               rsp_tvalid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_tdata_ff;

   logic [32:0]        ax0;
   logic [32:0]        ay0;
   logic [32:0]        m0;
   logic               dir_kind;
   logic               out_free;
   logic               load_out;
   logic               cordic_dir;
   logic signed [33:0] at_s;
   logic signed [33:0] c_neg;
   logic signed [33:0] s_neg;
   logic signed [33:0] c_rnd;
   logic signed [33:0] s_rnd;
   logic signed [17:0] b_s;
   logic signed [17:0] ob_s;
   logic signed [37:0] sp_x;
   logic signed [37:0] sp_y;
   logic signed [17:0] map_x;
   logic signed [17:0] map_y;
   logic signed [49:0] w_prod;
   logic signed [49:0] w_rnd;
   logic signed [57:0] d_prod;
   logic signed [57:0] d_rnd;
   logic signed [33:0] fold_r;
   logic signed [33:0] fold_r1;
   logic [33:0]        mod_step;

   function automatic logic signed [39:0] sat_acc(input logic signed [39:0] a,
                                                 input logic signed [33:0] b);
      logic signed [40:0] sum;
      sum = 41'(a) + 41'(b);
      if (sum[40] != sum[39]) begin
         return sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
      end
      return sum[39:0];
   endfunction

   function automatic logic signed [31:0] sat_word(input logic signed [57:0] v);
      if (v > 58'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -58'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   always_comb begin
      ax0 = q_item.dx[32] ? 33'(-q_item.dx) : 33'(q_item.dx);
      ay0 = q_item.dy[32] ? 33'(-q_item.dy) : 33'(q_item.dy);
      m0  = (ax0 > ay0) ? ax0 : ay0;
      dir_kind = (q_item.kind == KIND_VORTEX) || (q_item.kind == KIND_SOURCE) ||
                 (q_item.kind == KIND_SINK) || (q_item.kind == KIND_SADDLE) ||
                 (q_item.kind == KIND_SPIRAL);
      out_free = !rsp_tvalid_ff || rsp_tready;

      cordic_dir = vec_ff ? !y_ff[45] : !z_ff[33];
      at_s = 34'(atan_deg(5'(iter_ff)));

      mod_step = 34'(FULL_S) << k_ff;
      fold_r   = $signed(u_ff);
      fold_r1  = (fold_r > HALF_S) ? fold_r - FULL_S : fold_r;

      c_neg = neg_ff ? -c_ff : c_ff;
      s_neg = neg_ff ? -s_ff : s_ff;
      c_rnd = (c_neg + 34'sd8192) >>> 14;
      s_rnd = (s_neg + 34'sd8192) >>> 14;

      b_s  = $signed({1'b0, blend_ff});
      ob_s = $signed({1'b0, ONE_Q16}) - b_s;
      sp_x = (38'(ob_s) * 38'(-uy_ff) + 38'(b_s) * 38'(-ux_ff) + 38'sd32768) >>> 16;
      sp_y = (38'(ob_s) * 38'(ux_ff) + 38'(b_s) * 38'(-uy_ff) + 38'sd32768) >>> 16;

      unique case (kind_ff)
         KIND_VORTEX: begin
            map_x = -uy_ff;
            map_y = ux_ff;
         end
         KIND_UNIFORM, KIND_SOURCE: begin
            map_x = ux_ff;
            map_y = uy_ff;
         end
         KIND_SINK: begin
            map_x = -ux_ff;
            map_y = -uy_ff;
         end
         KIND_SADDLE: begin
            map_x = ux_ff;
            map_y = -uy_ff;
         end
         KIND_SPIRAL: begin
            map_x = sp_x[17:0];
            map_y = sp_y[17:0];
         end
         default: begin
            map_x = '0;
            map_y = '0;
         end
      endcase

      w_prod = 50'((state_ff == ST_WX) ? vx_ff : vy_ff) * 50'(weight_ff);
      w_rnd  = (w_prod + 50'sd32768) >>> 16;
      d_prod = 58'((state_ff == ST_DX) ? acc_x_ff : acc_y_ff) *
               58'($signed({1'b0, decay_ff}));
      d_rnd  = (d_prod + 58'sd32768) >>> 16;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               priority if (q_item.kind == KIND_UNIFORM) begin
                  state_in = ST_MOD;
               end else if (dir_kind && (m0 != '0)) begin
                  state_in = ST_NORM;
               end else begin
                  state_in = ST_ROUND;
               end
            end
         end
         ST_NORM: if (m_ff >= NORM_LOW) begin
            state_in = ST_ITER;
         end
         ST_MOD: if (k_ff == 4'd0) begin
            state_in = ST_FOLD;
         end
         ST_FOLD: state_in = ST_ITER;
         ST_ITER: if (iter_ff == CW'(CORDIC_STEPS - 1)) begin
            state_in = ST_ROUND;
         end
         ST_ROUND: state_in = ST_SPX;
         ST_SPX: state_in = ST_SPY;
         ST_SPY: state_in = ST_WX;
         ST_WX: state_in = ST_WY;
         ST_WY: state_in = ST_ACC;
         ST_ACC: state_in = last_ff ? ST_DX : ST_IDLE;
         ST_DX: state_in = ST_DY;
         ST_DY: state_in = ST_PUSH;
         ST_PUSH: if (out_free) begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      q_pop    = (state_ff == ST_IDLE) && q_valid;
      load_out = (state_ff == ST_PUSH) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         acc_x_ff      <= '0;
         acc_y_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         if (state_ff == ST_WY) begin
            acc_x_ff <= sat_acc(acc_x_ff, wx_ff);
         end
         if (state_ff == ST_ACC) begin
            acc_y_ff <= sat_acc(acc_y_ff, wy_ff);
         end
         if (state_ff == ST_DY) begin
            acc_x_ff <= '0;
            acc_y_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            kind_ff   <= q_item.kind;
            blend_ff  <= q_item.blend;
            weight_ff <= q_item.weight;
            decay_ff  <= q_item.decay;
            last_ff   <= q_item.last;
            x_ff      <= 46'(q_item.dx);
            y_ff      <= 46'(q_item.dy);
            m_ff      <= 41'(m0);
            u_ff      <= 34'(q_item.angle) + MOD_BIAS;
            k_ff      <= 4'd8;
            c_ff      <= 34'(KINV);
            s_ff      <= '0;
            iter_ff   <= '0;
            vec_ff    <= 1'b1;
            neg_ff    <= 1'b0;
            ok_ff     <= (q_item.kind == KIND_UNIFORM) || (dir_kind && (m0 != '0));
         end
         ST_NORM: begin
            priority if (m_ff < COARSE_LIM) begin
               m_ff <= m_ff << 8;
               x_ff <= x_ff <<< 8;
               y_ff <= y_ff <<< 8;
            end else if (m_ff < NORM_LOW) begin
               m_ff <= m_ff << 1;
               x_ff <= x_ff <<< 1;
               y_ff <= y_ff <<< 1;
            end else begin
               if (x_ff[45]) begin
                  x_ff   <= -x_ff;
                  y_ff   <= -y_ff;
                  neg_ff <= 1'b1;
               end
            end
         end
         ST_MOD: begin
            if (u_ff >= mod_step) begin
               u_ff <= u_ff - mod_step;
            end
            k_ff <= k_ff - 4'd1;
         end
         ST_FOLD: begin
            vec_ff <= 1'b0;
            priority if (fold_r1 > QUART_S) begin
               z_ff   <= (fold_r1 - HALF_S) <<< 8;
               neg_ff <= 1'b1;
            end else if (fold_r1 < -QUART_S) begin
               z_ff   <= (fold_r1 + HALF_S) <<< 8;
               neg_ff <= 1'b1;
            end else begin
               z_ff <= fold_r1 <<< 8;
            end
         end
         ST_ITER: begin
            if (cordic_dir) begin
               x_ff <= x_ff + (y_ff >>> iter_ff);
               y_ff <= y_ff - (x_ff >>> iter_ff);
               c_ff <= c_ff - (s_ff >>> iter_ff);
               s_ff <= s_ff + (c_ff >>> iter_ff);
               z_ff <= z_ff - at_s;
            end else begin
               x_ff <= x_ff - (y_ff >>> iter_ff);
               y_ff <= y_ff + (x_ff >>> iter_ff);
               c_ff <= c_ff + (s_ff >>> iter_ff);
               s_ff <= s_ff - (c_ff >>> iter_ff);
               z_ff <= z_ff + at_s;
            end
            iter_ff <= iter_ff + CW'(1);
         end
         ST_ROUND: begin
            ux_ff <= ok_ff ? c_rnd[17:0] : '0;
            uy_ff <= ok_ff ? s_rnd[17:0] : '0;
         end
         ST_SPX: vx_ff <= map_x;
         ST_SPY: vy_ff <= map_y;
         ST_WX: wx_ff <= w_rnd[33:0];
         ST_WY: wy_ff <= w_rnd[33:0];
         ST_ACC: ;
         ST_DX: fx_ff <= sat_word(d_rnd);
         ST_DY: fy_ff <= sat_word(d_rnd);
         ST_PUSH: if (load_out) begin
            rsp_tdata_ff <= {fy_ff, fx_ff};
         end
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
`default_nettype wire

// ----- rtl/core/ffls_checker.sv -----
`default_nettype none
`include "flow_field_layer_superposition_defines.svh"
module ffls_checker import ffls_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_tvalid,
   input wire logic                     req_tready,
   input wire logic [REQ_DATA_BITS-1:0] req_tdata,
   input wire logic [2:0]               req_tuser,
   input wire logic                     req_tlast,
   input wire logic                     rsp_tvalid,
   input wire logic                     rsp_tready,
   input wire logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   logic [2:0] pend_ff;
   logic       last_in;
   logic       out_xfer;

   assign last_in  = req_tvalid && req_tready && req_tlast;
   assign out_xfer = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 3'd0;
      end else begin
         pend_ff <= pend_ff + 3'(last_in) - 3'(out_xfer);
      end
   end

   `FFLS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))
   `FFLS_ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_tvalid)
   `FFLS_ASSERT_IMPLY(a_rsp_needs_last, clock, reset, rsp_tvalid, pend_ff != 3'd0)
   `FFLS_ASSERT_IMPLY(a_no_spurious_tdata, clock, reset, req_tvalid && req_tready,
      pend_ff != 3'd7 || !req_tlast || ^req_tdata[247:241] == 1'b0 || req_tuser != 3'd7)

endmodule

bind flow_field_layer_superposition ffls_checker u_ffls_checker (.*);
`default_nettype wire

// ----- bench/testbench.sv -----
`default_nettype none
module testbench;
   import ffls_pkg::*;

   typedef struct {
      logic signed [31:0] px, py, cx, cy, ang, blend, wgt;
      logic [2:0]         kind;
      logic [16:0]        decay;
      logic               last;
   } layer_type;

   typedef struct {
      logic signed [31:0] fx, fy;
   } field_type;

   localparam int LIMIT_CYCLES = 600000;
   localparam longint ACC_HI = 64'sd549755813887;
   localparam longint ACC_LO = -64'sd549755813888;

   logic                     clock = 0;
   logic                     reset = 1;
   logic                     req_tvalid = 0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [2:0]               req_tuser = '0;
   logic                     req_tlast = 0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   layer_type  layer_q[$];
   field_type  field_q[$];
   layer_type  cur_layer;
   longint  sum_x = 0, sum_y = 0;
   int      errors = 0;
   int      sent = 0;
   int      pause_at = 600;
   int      send_gap = 0;
   int      stall = 0;
   int      cycles = 0;
   bit      calm_tx = 0, calm_rx = 0;

   longint atan_tab[16] = '{754974720, 445687602, 235489088, 119537938, 60000934,
      30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
      117342, 58671, 29335};

   flow_field_layer_superposition u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #2 clock = ~clock;

   function automatic longint round_shift(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint sat_word(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic bit unit_vector(input longint dx, input longint dy,
                                      output longint ux, output longint uy);
      longint ax, ay, m, x, y, c, s, tx, ty, tc, ts;
      int sh;
      bit flip;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      m = ax > ay ? ax : ay;
      sh = 0;
      c = KINV;
      s = 0;
      flip = 0;
      ux = 0;
      uy = 0;
      if (m == 0) return 0;
      while (m < (64'sd1 <<< 40)) begin m = m <<< 1; sh++; end
      while (m >= (64'sd1 <<< 41)) begin m = m >>> 1; sh--; end
      if (sh >= 0) begin
         x = dx <<< sh;
         y = dy <<< sh;
      end else begin
         x = dx >>> (-sh);
         y = dy >>> (-sh);
      end
      if (x < 0) begin x = -x; y = -y; flip = 1; end
      for (int i = 0; i < 16; i++) begin
         if (y >= 0) begin
            tx = x + (y >>> i); ty = y - (x >>> i);
            tc = c - (s >>> i); ts = s + (c >>> i);
         end else begin
            tx = x - (y >>> i); ty = y + (x >>> i);
            tc = c + (s >>> i); ts = s - (c >>> i);
         end
         x = tx; y = ty; c = tc; s = ts;
      end
      if (flip) begin c = -c; s = -s; end
      ux = round_shift(c, 14);
      uy = round_shift(s, 14);
      return 1;
   endfunction

   function automatic void cos_sin(input longint a, output longint co, output longint si);
      longint r, z, c, s, tc, ts;
      bit neg;
      r = a % DEG_FULL;
      c = KINV;
      s = 0;
      neg = 0;
      if (r < 0) r += DEG_FULL;
      if (r > DEG_HALF) r -= DEG_FULL;
      if (r > DEG_QUART) begin r -= DEG_HALF; neg = 1; end
      else if (r < -DEG_QUART) begin r += DEG_HALF; neg = 1; end
      z = r <<< 8;
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            tc = c - (s >>> i); ts = s + (c >>> i); z -= atan_tab[i];
         end else begin
            tc = c + (s >>> i); ts = s - (c >>> i); z += atan_tab[i];
         end
         c = tc; s = ts;
      end
      if (neg) begin c = -c; s = -s; end
      co = round_shift(c, 14);
      si = round_shift(s, 14);
   endfunction

   function automatic longint weighted(input longint d, input longint w);
      longint wh, wl;
      wh = w >>> 16;
      wl = w - (wh <<< 16);
      return d * wh + round_shift(d * wl, 16);
   endfunction

   function automatic longint acc_add(input longint a, input longint c);
      longint v;
      v = a + c;
      return v > ACC_HI ? ACC_HI : (v < ACC_LO ? ACC_LO : v);
   endfunction

   function automatic longint damped(input longint a, input longint d);
      longint hi, lo;
      hi = a >>> 16;
      lo = a - (hi <<< 16);
      return hi * d + ((lo * d + 32768) >>> 16);
   endfunction

   task automatic superpose_layer(input layer_type l);
      longint ux, uy, vx, vy, b, d;
      bit ok;
      field_type f;
      ux = 0; uy = 0; vx = 0; vy = 0; ok = 0;
      if (l.kind != KIND_UNIFORM)
         ok = unit_vector(longint'(l.px) - longint'(l.cx),
                          longint'(l.py) - longint'(l.cy), ux, uy);
      case (l.kind)
         KIND_VORTEX: if (ok) begin vx = -uy; vy = ux; end
         KIND_UNIFORM: cos_sin(longint'(l.ang), vx, vy);
         KIND_SOURCE: if (ok) begin vx = ux; vy = uy; end
         KIND_SINK: if (ok) begin vx = -ux; vy = -uy; end
         KIND_SADDLE: if (ok) begin vx = ux; vy = -uy; end
         KIND_SPIRAL: if (ok) begin
            b = l.blend < 0 ? 0 : (l.blend > 65536 ? 65536 : longint'(l.blend));
            vx = round_shift((65536 - b) * (-uy) + b * (-ux), 16);
            vy = round_shift((65536 - b) * ux + b * (-uy), 16);
         end
         default: ;
      endcase
      sum_x = acc_add(sum_x, weighted(vx, l.wgt));
      sum_y = acc_add(sum_y, weighted(vy, l.wgt));
      if (l.last) begin
         d = l.decay > ONE_Q16 ? 65536 : longint'(l.decay);
         f.fx = 32'(sat_word(damped(sum_x, d)));
         f.fy = 32'(sat_word(damped(sum_y, d)));
         field_q.push_back(f);
         sum_x = 0;
         sum_y = 0;
      end
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h, expected %h", what, got, want);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [31:0] rand_coord();
      int r;
      r = $urandom_range(0, 3);
      if (r == 0) return $urandom;
      if (r == 1) return $signed($urandom_range(0, 32'h3fffff)) - 32'sh200000;
      return $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
   endfunction

   task automatic add_layer(input logic signed [31:0] px, py, cx, cy, ang, blend, wgt,
                            input logic [2:0] kind, input logic [16:0] decay,
                            input logic last);
      layer_type l;
      l.px = px; l.py = py; l.cx = cx; l.cy = cy; l.ang = ang; l.blend = blend;
      l.wgt = wgt; l.kind = kind; l.decay = decay; l.last = last;
      layer_q.push_back(l);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            superpose_layer(cur_layer);
            sent = sent + 1;
            if (sent % 150 == 0) calm_tx = ~calm_tx;
         end
         if (send_gap > 0) begin
            send_gap = send_gap - 1;
            req_tvalid <= 0;
         end else if (sent == pause_at && field_q.size() != 0) begin
            req_tvalid <= 0;
         end else if (layer_q.size() != 0) begin
            cur_layer = layer_q.pop_front();
            req_tdata <= {7'd0, cur_layer.decay, cur_layer.wgt, cur_layer.blend,
                          cur_layer.ang, cur_layer.cy, cur_layer.cx, cur_layer.py,
                          cur_layer.px};
            req_tuser <= cur_layer.kind;
            req_tlast <= cur_layer.last;
            req_tvalid <= 1;
            send_gap = calm_tx ? 0 : pick_gap();
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   always @(posedge clock) begin
      field_type f;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (field_q.size() == 0) begin
            report("unexpected transfer", rsp_tdata[31:0], 32'h0);
         end else begin
            f = field_q.pop_front();
            if (rsp_tdata[31:0] !== f.fx) report("field_x", rsp_tdata[31:0], f.fx);
            if (rsp_tdata[63:32] !== f.fy) report("field_y", rsp_tdata[63:32], f.fy);
         end
         if ($urandom_range(0, 99) == 0) calm_rx = ~calm_rx;
      end
      if (reset) begin
         rsp_tready <= 0;
      end else if (stall > 0) begin
         stall = stall - 1;
         rsp_tready <= 0;
      end else begin
         stall = calm_rx ? 0 : pick_gap();
         rsp_tready <= (stall == 0);
      end
   end

   always @(posedge clock) begin
      if (cycles >= LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int n;
      logic signed [31:0] px, py;
      logic [2:0] k;
      add_layer(0, 0, 0, 0, 0, 0, 32'sh10000, KIND_VORTEX, 17'd65536, 1);
      add_layer(32'sh30000, 32'sh40000, 0, 0, 0, 0, 32'sh10000, KIND_VORTEX, 17'd65536, 1);
      add_layer(0, 0, 0, 0, 32'sh2d0000, 0, 32'sh20000, KIND_UNIFORM, 17'd65536, 1);
      add_layer(0, 0, 0, 0, -32'sh870000, 0, 32'sh10000, KIND_UNIFORM, 17'd32768, 1);
      add_layer(0, 0, 0, 0, 32'h7fffffff, 0, 32'h7fffffff, KIND_UNIFORM, 17'd65536, 1);
      add_layer(0, 0, 0, 0, 32'h80000000, 0, 32'h80000000, KIND_UNIFORM, 17'd131071, 1);
      add_layer(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 0, 0,
                32'h7fffffff, KIND_SOURCE, 17'd65536, 1);
      add_layer(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0, 0,
                32'h80000000, KIND_SINK, 17'd0, 1);
      add_layer(1, 0, 0, 0, 0, 0, 32'sh10000, KIND_SADDLE, 17'd65536, 1);
      add_layer(-1, -1, 0, 0, 0, 32'sh8000, 32'sh10000, KIND_SPIRAL, 17'd65536, 1);
      add_layer(5, 7, 0, 0, 0, -32'sh10000, 32'sh10000, KIND_SPIRAL, 17'd65536, 1);
      add_layer(5, 7, 0, 0, 0, 32'sh7fffffff, 32'sh10000, KIND_SPIRAL, 17'd65536, 1);
      add_layer(9, 9, 9, 9, 0, 32'sh8000, 32'sh10000, KIND_SPIRAL, 17'd65536, 1);
      add_layer(1, 2, 3, 4, 0, 0, 32'sh10000, 3'd6, 17'd65536, 0);
      add_layer(1, 2, 3, 4, 0, 0, 32'sh10000, 3'd7, 17'd65536, 1);
      for (int i = 0; i < 6; i++)
         add_layer(0, 0, 0, 0, 0, 0, 32'h7fffffff, KIND_UNIFORM, 17'd65536, i == 5);
      for (int i = 0; i < 4; i++)
         add_layer(0, 0, 0, 0, 0, 0, 32'h80000000, KIND_UNIFORM, 17'd100000, i == 3);
      while (layer_q.size() < 1075) begin
         n = $urandom_range(1, 6);
         px = rand_coord();
         py = rand_coord();
         for (int i = 0; i < n; i++) begin
            k = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5));
            add_layer(px, py,
                      ($urandom_range(0, 9) == 0) ? px : rand_coord(),
                      ($urandom_range(0, 9) == 0) ? py : rand_coord(),
                      ($urandom_range(0, 1) == 0) ? 32'($urandom)
                         : $signed($urandom_range(0, 32'h2d00000)) - 32'sh1680000,
                      ($urandom_range(0, 3) == 0) ? 32'($urandom)
                         : 32'($urandom_range(0, 65536)),
                      ($urandom_range(0, 4) == 0) ? 32'($urandom)
                         : $signed($urandom_range(0, 32'h1000000)) - 32'sh800000,
                      k,
                      ($urandom_range(0, 4) == 0) ? 17'($urandom)
                         : 17'($urandom_range(0, 65536)),
                      i == n - 1);
         end
      end
      repeat (7) @(posedge clock);
      reset <= 0;
      wait (layer_q.size() == 0 && !req_tvalid);
      wait (field_q.size() == 0);
      repeat (80) @(posedge clock);
      if (errors == 0 && field_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+rtl/core
rtl/core/ffls_pkg.sv
rtl/core/ffls_front.sv
rtl/core/ffls_back.sv
rtl/core/flow_field_layer_superposition.sv
rtl/core/ffls_checker.sv
bench/testbench.sv
